>>> sv/tmps_pkg.sv
package tmps_pkg;

   // Store geometry: element (r,c) lives at address {r,c}
   localparam int DIM_BITS    = 4;
   localparam int ADDR_BITS   = 2 * DIM_BITS;
   localparam int STORE_DEPTH = 1 << ADDR_BITS;

   // Datapath widths
   localparam int VALUE_BITS  = 16;   // Q8.8 element
   localparam int PP_BITS     = 36;   // A*B, Q20.16
   localparam int PROD_BITS   = PP_BITS + VALUE_BITS;
   localparam int RESULT_BITS = 64;   // Q40.24
   localparam int ALIGN_SHIFT = 8;    // Q16.16 -> Q40.24

   typedef enum logic [1:0] {
      OP_LOAD_A  = 2'd0,
      OP_LOAD_B  = 2'd1,
      OP_COMPUTE = 2'd2,
      OP_READ    = 2'd3
   } opcode_type;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // Which sum a MAC beat belongs to
   typedef enum logic [1:0] {
      MODE_AB,      // P = A*B over upper triangle
      MODE_LEFT,    // P*B^T
      MODE_RIGHT    // A^T*A, aligned by ALIGN_SHIFT
   } mac_mode_type;

   typedef struct packed {
      logic                 valid;
      logic                 first;
      logic                 last;
      mac_mode_type         mode;
      logic [ADDR_BITS-1:0] dst_addr;
   } mac_op_type;

   typedef struct packed {
      logic                   p_we;
      logic                   r_we;
      logic [ADDR_BITS-1:0]   addr;
      logic [RESULT_BITS-1:0] data;
   } mac_wr_type;

endpackage

>>> sv/tmps_ram.sv
module tmps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/tmps_seq.sv
module tmps_seq #(
   parameter int MATRIX_SIZE = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   output tmps_pkg::mac_op_type           op,
   output logic [tmps_pkg::ADDR_BITS-1:0] a0_addr,
   output logic [tmps_pkg::ADDR_BITS-1:0] a1_addr,
   output logic [tmps_pkg::ADDR_BITS-1:0] b_addr,
   output logic [tmps_pkg::ADDR_BITS-1:0] p_addr
);
   import tmps_pkg::*;

   localparam logic [DIM_BITS-1:0] LAST = DIM_BITS'(MATRIX_SIZE - 1);

   logic                active_ff, active_in;
   mac_mode_type        mode_ff, mode_in;
   logic [DIM_BITS-1:0] i_ff, i_in;
   logic [DIM_BITS-1:0] j_ff, j_in;
   logic [DIM_BITS-1:0] k_ff, k_in;
   logic [DIM_BITS-1:0] lim;
   logic                k_end;

   // End of the inner sum for the current (i,j)
   always_comb begin
      lim   = (i_ff < j_ff) ? i_ff : j_ff;
      k_end = (mode_ff == MODE_RIGHT) ? (k_ff == lim) : (k_ff == LAST);
   end

   // Beat tag and store addresses
   always_comb begin
      op.valid    = active_ff;
      op.first    = ((mode_ff == MODE_AB) && (k_ff == i_ff)) ||
                    ((mode_ff == MODE_LEFT) && (k_ff == '0));
      op.last     = (mode_ff != MODE_LEFT) && k_end;
      op.mode     = mode_ff;
      op.dst_addr = {i_ff, j_ff};
      a0_addr     = {i_ff, k_ff};
      a1_addr     = {k_ff, j_ff};
      b_addr      = {k_ff, j_ff};
      p_addr      = {i_ff, k_ff};
      case (mode_ff)
         MODE_AB: begin
            a0_addr = {i_ff, k_ff};
            b_addr  = {k_ff, j_ff};
         end
         MODE_LEFT: begin
            p_addr = {i_ff, k_ff};
            b_addr = {j_ff, k_ff};
         end
         MODE_RIGHT: begin
            a0_addr = {k_ff, i_ff};
            a1_addr = {k_ff, j_ff};
         end
         default: begin
            a0_addr = {i_ff, k_ff};
         end
      endcase
   end

   // Loop counters
   always_comb begin
      active_in = active_ff;
      mode_in   = mode_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      if (start) begin
         active_in = 1'b1;
         mode_in   = MODE_AB;
         i_in      = '0;
         j_in      = '0;
         k_in      = '0;
      end else if (active_ff) begin
         case (mode_ff)
            MODE_AB: begin
               if (!k_end) begin
                  k_in = k_ff + 1'b1;
               end else if (j_ff != LAST) begin
                  j_in = j_ff + 1'b1;
                  k_in = i_ff;
               end else if (i_ff != LAST) begin
                  j_in = '0;
                  i_in = i_ff + 1'b1;
                  k_in = i_ff + 1'b1;
               end else begin
                  mode_in = MODE_LEFT;
                  i_in    = '0;
                  j_in    = '0;
                  k_in    = '0;
               end
            end
            MODE_LEFT: begin
               if (k_end) begin
                  mode_in = MODE_RIGHT;
                  k_in    = '0;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
            MODE_RIGHT: begin
               if (!k_end) begin
                  k_in = k_ff + 1'b1;
               end else begin
                  mode_in = MODE_LEFT;
                  k_in    = '0;
                  if (j_ff != LAST) begin
                     j_in = j_ff + 1'b1;
                  end else begin
                     j_in = '0;
                     if (i_ff != LAST) begin
                        i_in = i_ff + 1'b1;
                     end else begin
                        i_in      = '0;
                        active_in = 1'b0;
                     end
                  end
               end
            end
            default: begin
               active_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         mode_ff   <= MODE_AB;
         i_ff      <= '0;
         j_ff      <= '0;
         k_ff      <= '0;
      end else begin
         active_ff <= active_in;
         mode_ff   <= mode_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         k_ff      <= k_in;
      end
   end

   assign busy = active_ff;

endmodule

>>> sv/tmps_mac.sv
module tmps_mac (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tmps_pkg::mac_op_type                   op,
   input  logic signed [tmps_pkg::VALUE_BITS-1:0] a0_data,
   input  logic signed [tmps_pkg::VALUE_BITS-1:0] a1_data,
   input  logic signed [tmps_pkg::VALUE_BITS-1:0] b_data,
   input  logic signed [tmps_pkg::PP_BITS-1:0]    p_data,
   output tmps_pkg::mac_wr_type                   wr,
   output logic                                   idle
);
   import tmps_pkg::*;

   mac_op_type                    s1_ff, s2_ff;
   logic signed [PP_BITS-1:0]     opa;
   logic signed [VALUE_BITS-1:0]  opb;
   logic signed [PROD_BITS-1:0]   prod_in, prod_ff;
   logic signed [RESULT_BITS-1:0] prod_ext, addend, base;
   logic signed [RESULT_BITS-1:0] acc_in, acc_ff;

   // Stage 1: operands arrive from the stores, one multiply
   always_comb begin
      case (s1_ff.mode)
         MODE_AB: begin
            opa = PP_BITS'(a0_data);
            opb = b_data;
         end
         MODE_LEFT: begin
            opa = p_data;
            opb = b_data;
         end
         MODE_RIGHT: begin
            opa = PP_BITS'(a0_data);
            opb = a1_data;
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
      prod_in = opa * opb;
   end

   // Stage 2: accumulate; A^T*A terms are aligned to Q40.24
   always_comb begin
      prod_ext = RESULT_BITS'(prod_ff);
      addend   = (s2_ff.mode == MODE_RIGHT) ? (prod_ext <<< ALIGN_SHIFT) : prod_ext;
      base     = s2_ff.first ? '0 : acc_ff;
      acc_in   = base + addend;
   end

   // Finished sums go to the P or R store
   always_comb begin
      wr.p_we = s2_ff.valid && s2_ff.last && (s2_ff.mode == MODE_AB);
      wr.r_we = s2_ff.valid && s2_ff.last && (s2_ff.mode != MODE_AB);
      wr.addr = s2_ff.dst_addr;
      wr.data = acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
      end else begin
         s1_ff <= op;
         s2_ff <= s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (s2_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign idle = !s1_ff.valid && !s2_ff.valid;

endmodule

>>> sv/triangular_matrix_product_sum.sv
// Triangular matrix product-sum engine. Load an upper-triangular A and a full B
// (MATRIX_SIZE square, signed Q8.8) one element per beat, issue compute, then read
// R = (A*B)*B^T + A^T*A back as exact signed Q40.24, one element per read beat.
// Entries of A below the diagonal may be loaded but are ignored; loads and reads
// with row or col outside the matrix are dropped (reads return zero). Compute
// answers with one beat, kind 1 and value zero, when R is complete. The stores
// are not cleared at reset: every A and B element must be loaded before compute.
// A compute runs every product through one shared multiply-accumulate unit at
// one product per cycle and then drains the unit; the block takes no beat while
// it computes.
module triangular_matrix_product_sum #(
   parameter int MATRIX_SIZE = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [1:0]                              req_opcode,
   input  logic [tmps_pkg::DIM_BITS-1:0]           req_row,
   input  logic [tmps_pkg::DIM_BITS-1:0]           req_col,
   input  logic signed [tmps_pkg::VALUE_BITS-1:0]  req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [tmps_pkg::RESULT_BITS-1:0] rsp_result_value,
   output logic                                    rsp_kind
);
   import tmps_pkg::*;

   localparam logic [DIM_BITS:0] SIZE_W = (DIM_BITS + 1)'(MATRIX_SIZE);

   state_type               state_ff, state_in;
   logic                    accept;
   logic                    in_matrix;
   logic                    start;
   logic                    load_a_we, load_b_we;
   logic [ADDR_BITS-1:0]    req_addr;
   logic                    read_inside_ff;

   logic                    seq_busy;
   mac_op_type              mac_op;
   logic [ADDR_BITS-1:0]    a0_addr, a1_addr, b_addr, p_addr;
   mac_wr_type              mac_wr;
   logic                    mac_idle;

   logic [VALUE_BITS-1:0]   a0_data, a1_data, b_data;
   logic [PP_BITS-1:0]      p_data;
   logic [RESULT_BITS-1:0]  r_data;

   logic                    rsp_valid_ff;
   logic [RESULT_BITS-1:0]  rsp_value_ff;
   logic                    rsp_kind_ff;
   logic                    rsp_load;
   logic [RESULT_BITS-1:0]  rsp_load_value;
   logic                    rsp_load_kind;

   // Request decode
   always_comb begin
      accept    = req_valid && req_ready;
      in_matrix = ({1'b0, req_row} < SIZE_W) && ({1'b0, req_col} < SIZE_W);
      req_addr  = {req_row, req_col};
      start     = accept && (opcode_type'(req_opcode) == OP_COMPUTE);
      load_a_we = accept && in_matrix && (opcode_type'(req_opcode) == OP_LOAD_A);
      load_b_we = accept && in_matrix && (opcode_type'(req_opcode) == OP_LOAD_B);
   end

   // Two copies of A give two reads per cycle for A^T*A
   tmps_ram #(.WIDTH(VALUE_BITS), .DEPTH(STORE_DEPTH)) u_a0_ram (
      .clock   (clock),
      .wr_en   (load_a_we),
      .wr_addr (req_addr),
      .wr_data (req_value),
      .rd_addr (a0_addr),
      .rd_data (a0_data)
   );

   tmps_ram #(.WIDTH(VALUE_BITS), .DEPTH(STORE_DEPTH)) u_a1_ram (
      .clock   (clock),
      .wr_en   (load_a_we),
      .wr_addr (req_addr),
      .wr_data (req_value),
      .rd_addr (a1_addr),
      .rd_data (a1_data)
   );

   tmps_ram #(.WIDTH(VALUE_BITS), .DEPTH(STORE_DEPTH)) u_b_ram (
      .clock   (clock),
      .wr_en   (load_b_we),
      .wr_addr (req_addr),
      .wr_data (req_value),
      .rd_addr (b_addr),
      .rd_data (b_data)
   );

   tmps_ram #(.WIDTH(PP_BITS), .DEPTH(STORE_DEPTH)) u_p_ram (
      .clock   (clock),
      .wr_en   (mac_wr.p_we),
      .wr_addr (mac_wr.addr),
      .wr_data (mac_wr.data[PP_BITS-1:0]),
      .rd_addr (p_addr),
      .rd_data (p_data)
   );

   tmps_ram #(.WIDTH(RESULT_BITS), .DEPTH(STORE_DEPTH)) u_r_ram (
      .clock   (clock),
      .wr_en   (mac_wr.r_we),
      .wr_addr (mac_wr.addr),
      .wr_data (mac_wr.data),
      .rd_addr (req_addr),
      .rd_data (r_data)
   );

   tmps_seq #(.MATRIX_SIZE(MATRIX_SIZE)) u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .busy    (seq_busy),
      .op      (mac_op),
      .a0_addr (a0_addr),
      .a1_addr (a1_addr),
      .b_addr  (b_addr),
      .p_addr  (p_addr)
   );

   tmps_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .op      (mac_op),
      .a0_data (a0_data),
      .a1_data (a1_data),
      .b_data  (b_data),
      .p_data  (p_data),
      .wr      (mac_wr),
      .idle    (mac_idle)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (opcode_type'(req_opcode))
                  OP_COMPUTE: state_in = ST_RUN;
                  OP_READ:    state_in = ST_READ;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ:  state_in = ST_IDLE;
         ST_RUN: begin
            if (!seq_busy) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_idle) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs of the controller
   always_comb begin
      req_ready      = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
      rsp_load       = (state_ff == ST_READ) || ((state_ff == ST_DRAIN) && mac_idle);
      rsp_load_value = ((state_ff == ST_READ) && read_inside_ff) ? r_data : '0;
      rsp_load_kind  = (state_ff == ST_DRAIN) ? KIND_DONE : KIND_READ;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_inside_ff <= in_matrix;
      end
   end

   // Response beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff <= rsp_load_value;
         rsp_kind_ff  <= rsp_load_kind;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_kind         = rsp_kind_ff;

   // The sequencer only runs while the controller is computing
   assert property (@(posedge clock) disable iff (reset)
      seq_busy |-> (state_ff == ST_RUN))
      else $error("sequencer busy outside compute");

   // Store writes from the MAC only during compute or drain
   assert property (@(posedge clock) disable iff (reset)
      (mac_wr.p_we || mac_wr.r_we) |-> (state_ff == ST_RUN || state_ff == ST_DRAIN))
      else $error("MAC store write outside compute");

   // Completion beat only after the MAC pipeline has emptied
   assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && rsp_kind_ff == KIND_DONE) |-> $past(mac_idle))
      else $error("compute finished before MAC drained");

endmodule

>>> tb/tb_triangular_matrix_product_sum.sv
module tb_triangular_matrix_product_sum;
   import tmps_pkg::*;

   // Small odd size so indices outside the matrix are reachable on 4-bit fields
   localparam int MATRIX_N     = 5;
   localparam int VALUE_MIN    = -32768;
   localparam int VALUE_MAX    = 32767;
   localparam int RANDOM_ITEMS = 30;
   localparam int HOLD_CYCLES  = 200;   // one long receiver hold-off
   localparam int TAIL_CYCLES  = 20;    // margin for the read and the compute drain
   localparam int IDLE_LIMIT   = 4000;

   typedef struct {
      opcode_type                   op;
      logic [DIM_BITS-1:0]          row;
      logic [DIM_BITS-1:0]          col;
      logic signed [VALUE_BITS-1:0] value;
      bit                           wait_idle;  // hold until all answers are back
   } command_type;

   typedef struct {
      logic                          kind;
      logic signed [RESULT_BITS-1:0] value;
   } answer_type;

   typedef enum int {
      STALL_NONE,
      STALL_COIN,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   logic                          clock;
   logic                          reset      = 1'b1;
   logic                          req_valid  = 1'b0;
   logic                          req_ready;
   logic [1:0]                    req_opcode = OP_LOAD_A;
   logic [DIM_BITS-1:0]           req_row    = '0;
   logic [DIM_BITS-1:0]           req_col    = '0;
   logic signed [VALUE_BITS-1:0]  req_value  = '0;
   logic                          rsp_valid;
   logic                          rsp_ready  = 1'b0;
   logic signed [RESULT_BITS-1:0] rsp_result_value;
   logic                          rsp_kind;

   command_type command_q[$];
   answer_type  answer_q[$];
   command_type offered_cmd;
   answer_type  oldest_answer;
   logic        next_valid;
   int          burst_left;
   int          gap_left;
   int          hold_left;
   bit          hold_done;
   int          stall_phase;
   int          idle_cycles;
   int          error_count;

   // Shadow copies of the matrices
   longint a_elem  [MATRIX_N][MATRIX_N];
   longint b_elem  [MATRIX_N][MATRIX_N];
   longint ab_elem [MATRIX_N][MATRIX_N];
   longint r_elem  [MATRIX_N][MATRIX_N];

   triangular_matrix_product_sum #(
      .MATRIX_SIZE(MATRIX_N)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_kind         (rsp_kind)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic flag_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   // R = (A*B)*B^T + A^T*A, A taken as upper triangular
   function automatic void form_product_sum();
      longint acc;
      longint left_sum;
      longint right_sum;
      int     lim;
      for (int i = 0; i < MATRIX_N; i++) begin
         for (int j = 0; j < MATRIX_N; j++) begin
            acc = 0;
            for (int k = i; k < MATRIX_N; k++)
               acc += a_elem[i][k] * b_elem[k][j];
            ab_elem[i][j] = acc;
         end
      end
      for (int i = 0; i < MATRIX_N; i++) begin
         for (int j = 0; j < MATRIX_N; j++) begin
            left_sum  = 0;
            right_sum = 0;
            lim       = (i < j) ? i : j;
            for (int k = 0; k < MATRIX_N; k++)
               left_sum += ab_elem[i][k] * b_elem[j][k];
            for (int k = 0; k <= lim; k++)
               right_sum += a_elem[k][i] * a_elem[k][j];
            // A^T*A is Q16.16, shift up to Q40.24
            r_elem[i][j] = left_sum + (right_sum <<< ALIGN_SHIFT);
         end
      end
   endfunction

   // Update the shadow state for one accepted beat, queue its answer if any
   function automatic void apply_command(command_type cmd);
      bit         in_range;
      answer_type ans;
      in_range = (cmd.row < MATRIX_N) && (cmd.col < MATRIX_N);
      case (cmd.op)
         OP_LOAD_A: begin
            if (in_range) a_elem[cmd.row][cmd.col] = cmd.value;
         end
         OP_LOAD_B: begin
            if (in_range) b_elem[cmd.row][cmd.col] = cmd.value;
         end
         OP_COMPUTE: begin
            form_product_sum();
            ans.kind  = KIND_DONE;
            ans.value = '0;
            answer_q.push_back(ans);
         end
         default: begin
            ans.kind  = KIND_READ;
            ans.value = in_range ? r_elem[cmd.row][cmd.col] : '0;
            answer_q.push_back(ans);
         end
      endcase
   endfunction

   task automatic queue_cmd(input opcode_type op, input int row, input int col,
                            input int value, input bit wait_idle = 1'b0);
      command_type cmd;
      cmd.op        = op;
      cmd.row       = DIM_BITS'(row);
      cmd.col       = DIM_BITS'(col);
      cmd.value     = VALUE_BITS'(value);
      cmd.wait_idle = wait_idle;
      command_q.push_back(cmd);
   endtask

   // Mostly inside the matrix, sometimes anywhere on the 4-bit field
   function automatic int pick_index();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 15);
      return $urandom_range(0, MATRIX_N - 1);
   endfunction

   function automatic int pick_value();
      case ($urandom_range(0, 9))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2:       return 0;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   // Driver: sends beats from command_q in bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            apply_command(offered_cmd);
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (command_q.size() > 0 &&
                         !(command_q[0].wait_idle && answer_q.size() > 0)) begin
               offered_cmd = command_q.pop_front();
               req_opcode <= offered_cmd.op;
               req_row    <= offered_cmd.row;
               req_col    <= offered_cmd.col;
               req_value  <= offered_cmd.value;
               next_valid = 1'b1;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                           : $urandom_range(1, 8);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         req_valid <= next_valid;
      end
   end

   // Receiver: rotating stall pattern, plus one long hold after the first compute
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         hold_left   = 0;
         hold_done   = 1'b0;
         stall_phase = 0;
      end else begin
         if (!hold_done && rsp_valid && rsp_ready && rsp_kind == KIND_DONE) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         stall_phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (stall_mode_type'((stall_phase / 40) % 4))
               STALL_NONE:     rsp_ready <= 1'b1;
               STALL_COIN:     rsp_ready <= ($urandom_range(0, 1) == 0);
               STALL_PERIODIC: rsp_ready <= (stall_phase % 4 != 0);
               default:        rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Monitor: each result beat against the oldest expected answer
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (answer_q.size() == 0) begin
            flag_error($sformatf("unexpected beat: kind %0d value %0d",
                                 rsp_kind, rsp_result_value));
         end else begin
            oldest_answer = answer_q.pop_front();
            if (rsp_kind !== oldest_answer.kind)
               flag_error($sformatf("kind: got %0d want %0d",
                                    rsp_kind, oldest_answer.kind));
            if (rsp_result_value !== oldest_answer.value)
               flag_error($sformatf("result_value: got %0d want %0d",
                                    rsp_result_value, oldest_answer.value));
         end
      end
   end

   // Watchdog: too long with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("tb_triangular_matrix_product_sum: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int         n_loads;
      int         n_reads;
      int         seq_count;
      int         counted;
      int         row;
      int         col;
      opcode_type op;

      error_count = 0;
      idle_cycles = 0;

      // Fill both matrices with the most negative value: largest magnitudes
      for (int r = 0; r < MATRIX_N; r++) begin
         for (int c = 0; c < MATRIX_N; c++) begin
            queue_cmd(OP_LOAD_A, r, c, VALUE_MIN);
            queue_cmd(OP_LOAD_B, r, c, VALUE_MIN);
         end
      end
      queue_cmd(OP_COMPUTE, 15, 15, VALUE_MAX);
      // Corners, then reads outside the matrix
      queue_cmd(OP_READ, 0, 0, 0);
      queue_cmd(OP_READ, MATRIX_N - 1, MATRIX_N - 1, 0);
      queue_cmd(OP_READ, 0, MATRIX_N - 1, 0);
      queue_cmd(OP_READ, MATRIX_N - 1, 0, 0);
      queue_cmd(OP_READ, 15, 15, 0);
      queue_cmd(OP_READ, MATRIX_N, 0, 0);
      queue_cmd(OP_READ, 0, MATRIX_N, 0);
      // Below-diagonal A load, loads outside the matrix, mixed extremes
      queue_cmd(OP_LOAD_A, MATRIX_N - 1, 0, VALUE_MAX, 1'b1);
      queue_cmd(OP_LOAD_A, 15, 3, 1);
      queue_cmd(OP_LOAD_B, 2, 15, VALUE_MAX);
      queue_cmd(OP_LOAD_B, 0, 0, VALUE_MAX);
      queue_cmd(OP_LOAD_A, 0, 0, 0);
      queue_cmd(OP_LOAD_A, 1, 1, VALUE_MAX);
      queue_cmd(OP_COMPUTE, 0, 0, 0);
      queue_cmd(OP_READ, 0, 0, 0);
      queue_cmd(OP_READ, MATRIX_N - 1, 0, 0);
      queue_cmd(OP_READ, 1, 1, 0);
      queue_cmd(OP_READ, 0, MATRIX_N - 1, 0);
      queue_cmd(OP_READ, MATRIX_N - 1, MATRIX_N - 1, 0);

      // Random sequences: a few loads, usually a compute, then reads
      seq_count = 0;
      counted   = 0;
      while (counted < RANDOM_ITEMS) begin
         n_loads = $urandom_range(0, 10);
         for (int i = 0; i < n_loads; i++) begin
            op  = ($urandom_range(0, 1) == 0) ? OP_LOAD_A : OP_LOAD_B;
            row = pick_index();
            col = pick_index();
            queue_cmd(op, row, col, pick_value(), (i == 0) && (seq_count % 4 == 3));
            if (row < MATRIX_N && col < MATRIX_N) counted++;
         end
         if ($urandom_range(0, 3) != 0) begin
            queue_cmd(OP_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15),
                      pick_value());
            counted++;
         end
         n_reads = $urandom_range(1, 8);
         for (int i = 0; i < n_reads; i++) begin
            queue_cmd(OP_READ, pick_index(), pick_index(), pick_value());
            counted++;
         end
         seq_count++;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Wait for all beats sent and all answers back, then let the block settle
      @(negedge clock);
      while (command_q.size() != 0 || req_valid || answer_q.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("tb_triangular_matrix_product_sum: done, clean");
      end else begin
         $display("tb_triangular_matrix_product_sum: done, errors");
      end
      $finish;
   end

endmodule

>>> files.f
sv/tmps_pkg.sv
sv/tmps_ram.sv
sv/tmps_seq.sv
sv/tmps_mac.sv
sv/triangular_matrix_product_sum.sv
tb/tb_triangular_matrix_product_sum.sv
